>>> src/utf8_stream_validator_defines.svh
// assertion macros for the utf8 stream validator
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define U8SV_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8sv assertion failed");

// next-cycle implication, off during reset
`define U8SV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8sv assertion failed");

`endif

>>> src/u8sv_pkg.sv
// shared types and constants for the utf8 stream validator
package u8sv_pkg;

  localparam int unsigned ACC_W = 21;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;

  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  localparam logic [ACC_W-1:0] CP_MIN_TWO   = 21'h00080;
  localparam logic [ACC_W-1:0] CP_MIN_THREE = 21'h00800;
  localparam logic [ACC_W-1:0] CP_MIN_FOUR  = 21'h10000;
  localparam logic [ACC_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [ACC_W-1:0] SURR_LO      = 21'h0D800;
  localparam logic [ACC_W-1:0] SURR_HI      = 21'h0DFFF;

  typedef struct packed {
    logic [1:0]       pending;
    logic [1:0]       seq_len;
    logic [ACC_W-1:0] accum;
    logic             err_seen;
  } u8sv_state_t;

endpackage

>>> src/u8sv_in_if.sv
// byte input channel of the utf8 stream validator
interface u8sv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/u8sv_out_if.sv
// verdict output channel of the utf8 stream validator
interface u8sv_out_if;
  logic valid;
  logic ready;
  logic string_valid;

  modport source (output valid, output string_valid, input ready);
  modport sink   (input valid, input string_valid, output ready);
endinterface

>>> src/utf8_stream_validator.sv
// utf8 stream validator top level
//
// in_chan carries one byte of a string per transaction, with last_byte set
// on the final byte. out_chan carries one transaction per string, string_valid
// set when the whole string is strict utf-8 (no stray control bytes, no bad
// lead or continuation bytes, no truncation, no overlong forms, no surrogates,
// nothing above U+10FFFF).
// one byte is taken per cycle while in_chan is ready; the verdict shows on
// out_chan in the cycle after the final byte is accepted. the per-byte decode
// is a single combinational step between the state and verdict registers.
// reset clears the decode state and drops out_chan.valid; the next byte starts
// a new string. a verdict that is not taken holds on out_chan, and in_chan
// stays ready only while the verdict register is empty or being drained in
// the same cycle, so no verdict is lost or overwritten.
// an empty string cannot be presented and is left to the caller.
module utf8_stream_validator (
  input logic        clk,
  input logic        rst_n,
  u8sv_in_if.sink    in_chan,
  u8sv_out_if.source out_chan
);
  import u8sv_pkg::*;

  u8sv_state_t st_r;
  u8sv_state_t st_nxt;
  u8sv_state_t step_st;
  logic        verdict;
  logic        in_fire;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_string_valid_r;
  logic        out_string_valid_nxt;

  u8sv_step u_step (
    .st_i        (st_r),
    .data_byte_i (in_chan.data_byte),
    .last_byte_i (in_chan.last_byte),
    .st_o        (step_st),
    .verdict_o   (verdict)
  );

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    st_nxt               = st_r;
    out_valid_nxt        = out_valid_r;
    out_string_valid_nxt = out_string_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      st_nxt = step_st;
      if (in_chan.last_byte) begin
        out_valid_nxt        = 1'b1;
        out_string_valid_nxt = verdict;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_string_valid_r <= out_string_valid_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.string_valid = out_string_valid_r;
endmodule

>>> src/u8sv_step.sv
// next-state and verdict logic for one byte of the utf8 stream validator
module u8sv_step (
  input  u8sv_pkg::u8sv_state_t st_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output u8sv_pkg::u8sv_state_t st_o,
  output logic                  verdict_o
);
  import u8sv_pkg::*;

  u8sv_state_t      nx;
  logic [ACC_W-1:0] cp;
  logic [1:0]       pend_dec;
  logic             overlong;
  logic             bad_cp;

  assign cp       = {st_i.accum[ACC_W-7:0], data_byte_i[5:0]};
  assign pend_dec = st_i.pending - 2'd1;
  assign overlong = (st_i.seq_len == SEQ_TWO   && cp < CP_MIN_TWO)   ||
                    (st_i.seq_len == SEQ_THREE && cp < CP_MIN_THREE) ||
                    (st_i.seq_len == SEQ_FOUR  && cp < CP_MIN_FOUR);
  assign bad_cp   = overlong || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI);

  always_comb begin
    nx        = st_i;
    verdict_o = 1'b0;
    if (st_i.pending == 2'd0) begin
      if (!data_byte_i[7]) begin
        if (data_byte_i < CTRL_LIMIT && data_byte_i != CHAR_TAB && data_byte_i != CHAR_LF) begin
          nx          = '0;
          nx.err_seen = 1'b1;
        end
      end else if ((data_byte_i & LEAD2_MASK) == LEAD2_TAG) begin
        nx.seq_len = SEQ_TWO;
        nx.pending = SEQ_TWO;
        nx.accum   = ACC_W'(data_byte_i & LEAD2_BITS);
      end else if ((data_byte_i & LEAD3_MASK) == LEAD3_TAG) begin
        nx.seq_len = SEQ_THREE;
        nx.pending = SEQ_THREE;
        nx.accum   = ACC_W'(data_byte_i & LEAD3_BITS);
      end else if ((data_byte_i & LEAD4_MASK) == LEAD4_TAG) begin
        nx.seq_len = SEQ_FOUR;
        nx.pending = SEQ_FOUR;
        nx.accum   = ACC_W'(data_byte_i & LEAD4_BITS);
      end else begin
        nx          = '0;
        nx.err_seen = 1'b1;
      end
    end else begin
      if ((data_byte_i & CONT_MASK) != CONT_TAG) begin
        nx          = '0;
        nx.err_seen = 1'b1;
      end else begin
        nx.accum   = cp;
        nx.pending = pend_dec;
        if (pend_dec == 2'd0) begin
          if (bad_cp) begin
            nx          = '0;
            nx.err_seen = 1'b1;
          end else begin
            nx.seq_len = SEQ_NONE;
            nx.accum   = '0;
          end
        end
      end
    end
    // final byte: give the verdict and return to idle
    if (last_byte_i) begin
      verdict_o = !(nx.err_seen || nx.pending != 2'd0);
      nx        = '0;
    end
  end

  assign st_o = nx;
endmodule

>>> src/u8sv_checker.sv
// port checks for the utf8 stream validator, bound to the top level
`include "utf8_stream_validator_defines.svh"

module u8sv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_string_valid
);
  logic in_fire;
  logic out_free;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // stalled verdict holds
  `U8SV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_string_valid))
  // final byte gives a verdict in the next cycle
  `U8SV_ASSERT_NEXT(a_last_gives_verdict, in_fire && in_last, out_valid)
  // a byte that is not final never makes a verdict
  `U8SV_ASSERT_NEXT(a_no_spurious, in_fire && !in_last && out_free, !out_valid)
  // no byte is taken while a verdict is stuck
  `U8SV_ASSERT_IMPLY(a_block_on_stall, out_valid && !out_ready, !in_ready)
endmodule

bind utf8_stream_validator u8sv_checker u_u8sv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_last          (in_chan.last_byte),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_string_valid (out_chan.string_valid)
);
